FILE: src/biq_pkg.sv
// Shared types, register map and microcode program for the biquad low-pass filter.
package biq_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 18;
    localparam int DELAY_WIDTH_DEF  = 24;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_B0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_B1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_B2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_A1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEF_A2 = 3'd5;

    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] PC_START  = 4'd0;
    localparam logic [PC_W-1:0] PC_FB_1   = 4'd1;
    localparam logic [PC_W-1:0] PC_FB_2   = 4'd2;
    localparam logic [PC_W-1:0] PC_W_OUT  = 4'd3;
    localparam logic [PC_W-1:0] PC_FF_0   = 4'd4;
    localparam logic [PC_W-1:0] PC_FF_1   = 4'd5;
    localparam logic [PC_W-1:0] PC_FF_2   = 4'd6;
    localparam logic [PC_W-1:0] PC_FF_3   = 4'd7;
    localparam logic [PC_W-1:0] PC_FINISH = 4'd8;
    localparam logic [PC_W-1:0] PC_PASS   = 4'd9;

    typedef enum logic [2:0] {
        ACC_HOLD   = 3'd0,
        ACC_LOAD_X = 3'd1,
        ACC_LOAD_P = 3'd2,
        ACC_ADD    = 3'd3,
        ACC_SUB    = 3'd4
    } t_acc_op;

    typedef enum logic [2:0] {
        C_B0 = 3'd0,
        C_B1 = 3'd1,
        C_B2 = 3'd2,
        C_A1 = 3'd3,
        C_A2 = 3'd4
    } t_coef_sel;

    typedef enum logic [1:0] {
        OP_D1 = 2'd0,
        OP_D2 = 2'd1,
        OP_W  = 2'd2
    } t_opnd_sel;

    typedef struct packed {
        t_acc_op         acc_op;
        t_coef_sel       coef;
        t_opnd_sel       opnd;
        logic            mul_en;
        logic            w_latch;
        logic            finish;
        logic            pass;
        logic            jmp_dis;
        logic [PC_W-1:0] jmp_tgt;
    } t_uop;

    function automatic t_uop biq_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u.acc_op  = ACC_HOLD;
        u.coef    = C_B0;
        u.opnd    = OP_D1;
        u.mul_en  = 1'b0;
        u.w_latch = 1'b0;
        u.finish  = 1'b0;
        u.pass    = 1'b0;
        u.jmp_dis = 1'b0;
        u.jmp_tgt = PC_PASS;
        case (pc)
            PC_START: begin
                u.acc_op  = ACC_LOAD_X;
                u.coef    = C_A1;
                u.opnd    = OP_D1;
                u.mul_en  = 1'b1;
                u.jmp_dis = 1'b1;
                u.jmp_tgt = PC_PASS;
            end
            PC_FB_1: begin
                u.acc_op = ACC_SUB;
                u.coef   = C_A2;
                u.opnd   = OP_D2;
                u.mul_en = 1'b1;
            end
            PC_FB_2: begin
                u.acc_op = ACC_SUB;
            end
            PC_W_OUT: begin
                u.w_latch = 1'b1;
            end
            PC_FF_0: begin
                u.coef   = C_B0;
                u.opnd   = OP_W;
                u.mul_en = 1'b1;
            end
            PC_FF_1: begin
                u.acc_op = ACC_LOAD_P;
                u.coef   = C_B1;
                u.opnd   = OP_D1;
                u.mul_en = 1'b1;
            end
            PC_FF_2: begin
                u.acc_op = ACC_ADD;
                u.coef   = C_B2;
                u.opnd   = OP_D2;
                u.mul_en = 1'b1;
            end
            PC_FF_3: begin
                u.acc_op = ACC_ADD;
            end
            PC_FINISH: begin
                u.finish = 1'b1;
            end
            PC_PASS: begin
                u.finish = 1'b1;
                u.pass   = 1'b1;
            end
            default: begin
                u.finish = 1'b1;
                u.pass   = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

FILE: src/biq_if.sv
// Valid/ready stream interfaces for filter samples in and filtered samples out.
interface biq_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           guard_hit;

    modport source (output valid, output sample_out, output guard_hit, input ready);
    modport sink   (input valid, input sample_out, input guard_hit, output ready);
endinterface

FILE: src/biquad_lowpass_filter.sv
// Direct form II biquad low-pass filter run by a microcoded sequencer over one multiplier.
//
//   channel   dir   handshake          word
//   i_in      in    valid / ready      sample_in
//   o_out     out   valid / ready      sample_out, guard_hit
//   apb       in    psel/penable/...   enable, coef_b0..coef_b2, coef_a1, coef_a2
//
// Filtering: the five products share a single registered multiplier, so the sequencer
// steps through the whole program before the next word is taken. Bypass: the sequencer
// jumps from the start step straight to the pass step.
// i_rst_n clears enable, the coefficients, the delay line and the output valid flag.
// The final step holds while the output register is full and o_out.ready is low;
// a new word is taken only while the sequencer is idle.
module biquad_lowpass_filter
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
    parameter int DELAY_WIDTH  = DELAY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    biq_in_if.sink                i_in,
    biq_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int FRAC   = COEF_WIDTH - 2;
    localparam int PROD_W = COEF_WIDTH + DELAY_WIDTH;
    localparam int ACC_X  = COEF_WIDTH + DELAY_WIDTH + 3;
    localparam int ACC_W  = (ACC_X > 64) ? 64 : ACC_X;

    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(64'sd1 <<< (FRAC - 1));
    localparam logic signed [ACC_W-1:0] D_MAX =
        ACC_W'((64'sd1 <<< (DELAY_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] D_MIN = ACC_W'(-(64'sd1 <<< (DELAY_WIDTH - 1)));
    localparam logic signed [ACC_W-1:0] S_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] S_MIN = ACC_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    // configuration registers
    logic                         r_enable;
    logic signed [COEF_WIDTH-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    // sequencer and datapath
    logic                          r_busy;
    logic [PC_W-1:0]               r_pc;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [DELAY_WIDTH-1:0] r_w;
    logic                          r_guard;
    logic signed [DELAY_WIDTH-1:0] r_d1, r_d2;

    // output register
    logic                           r_ovalid;
    logic signed [SAMPLE_WIDTH-1:0] r_osample;
    logic                           r_oguard;

    t_uop                           uop;
    logic                           stall;
    logic                           step;
    logic [REG_IDX_W-1:0]           cfg_idx;
    logic                           cfg_wr;
    logic signed [COEF_WIDTH-1:0]   mul_c;
    logic signed [DELAY_WIDTH-1:0]  mul_d;
    logic signed [ACC_W-1:0]        x_ext;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [ACC_W-1:0]        rnd_sum;
    logic signed [ACC_W-1:0]        rnd;
    logic                           w_ovf;
    logic signed [DELAY_WIDTH-1:0]  w_new;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic [PC_W-1:0]                n_pc;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_b0     <= '0;
            r_b1     <= '0;
            r_b2     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENABLE:  r_enable <= pwdata[0];
                REG_COEF_B0: r_b0     <= pwdata[COEF_WIDTH-1:0];
                REG_COEF_B1: r_b1     <= pwdata[COEF_WIDTH-1:0];
                REG_COEF_B2: r_b2     <= pwdata[COEF_WIDTH-1:0];
                REG_COEF_A1: r_a1     <= pwdata[COEF_WIDTH-1:0];
                REG_COEF_A2: r_a2     <= pwdata[COEF_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ENABLE:  prdata = {{(CFG_DATA_W-1){1'b0}}, r_enable};
            REG_COEF_B0: prdata = CFG_DATA_W'(r_b0);
            REG_COEF_B1: prdata = CFG_DATA_W'(r_b1);
            REG_COEF_B2: prdata = CFG_DATA_W'(r_b2);
            REG_COEF_A1: prdata = CFG_DATA_W'(r_a1);
            REG_COEF_A2: prdata = CFG_DATA_W'(r_a2);
            default:     prdata = '0;
        endcase
    end

    assign uop   = biq_rom(r_pc);
    assign stall = uop.finish && r_ovalid && !o_out.ready;
    assign step  = r_busy && !stall;

    assign i_in.ready = !r_busy;

    always_comb begin
        case (uop.coef)
            C_B0:    mul_c = r_b0;
            C_B1:    mul_c = r_b1;
            C_B2:    mul_c = r_b2;
            C_A1:    mul_c = r_a1;
            C_A2:    mul_c = r_a2;
            default: mul_c = '0;
        endcase
        case (uop.opnd)
            OP_D1:   mul_d = r_d1;
            OP_D2:   mul_d = r_d2;
            OP_W:    mul_d = r_w;
            default: mul_d = '0;
        endcase
    end

    assign x_ext    = ACC_W'(r_x);
    assign prod_ext = ACC_W'(r_prod);
    assign rnd_sum  = r_acc + HALF;
    assign rnd      = rnd_sum >>> FRAC;
    assign w_ovf    = (rnd > D_MAX) || (rnd < D_MIN);
    assign w_new    = w_ovf ? DELAY_WIDTH'(r_x) : DELAY_WIDTH'(rnd);

    always_comb begin
        if (rnd > S_MAX) begin
            y_sat = SAMPLE_WIDTH'(S_MAX);
        end else if (rnd < S_MIN) begin
            y_sat = SAMPLE_WIDTH'(S_MIN);
        end else begin
            y_sat = SAMPLE_WIDTH'(rnd);
        end
    end

    always_comb begin
        if (uop.jmp_dis && !r_enable) begin
            n_pc = uop.jmp_tgt;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_START;
        end else if (i_in.valid && i_in.ready) begin
            r_busy <= 1'b1;
            r_pc   <= PC_START;
        end else if (step) begin
            r_pc <= n_pc;
            if (uop.finish) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_x <= i_in.sample_in;
        end
        if (step && uop.mul_en) begin
            r_prod <= mul_c * mul_d;
        end
        if (step) begin
            case (uop.acc_op)
                ACC_LOAD_X: r_acc <= x_ext <<< FRAC;
                ACC_LOAD_P: r_acc <= prod_ext;
                ACC_ADD:    r_acc <= r_acc + prod_ext;
                ACC_SUB:    r_acc <= r_acc - prod_ext;
                default:    r_acc <= r_acc;
            endcase
        end
        if (step && uop.w_latch) begin
            r_w     <= w_new;
            r_guard <= w_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (step && uop.finish && !uop.pass) begin
            r_d1 <= r_w;
            r_d2 <= r_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (step && uop.finish) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && uop.finish) begin
            if (uop.pass) begin
                r_osample <= r_x;
                r_oguard  <= 1'b0;
            end else begin
                r_osample <= y_sat;
                r_oguard  <= r_guard;
            end
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.sample_out = r_osample;
    assign o_out.guard_hit  = r_oguard;

endmodule

FILE: sim/tb_biquad_lowpass_filter.sv
// Self-checking testbench for the biquad low-pass filter: directed and random words vs. a predictor.
`timescale 1ns / 1ps

module tb_biquad_lowpass_filter;
    import biq_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int N_RANDOM     = 1750;
    localparam int LONG_HOLD    = 300;
    localparam int N_DIR        = 35;

    localparam logic signed [15:0] S_MAX = 16'sh7FFF;
    localparam logic signed [15:0] S_MIN = 16'sh8000;
    localparam longint DLY_MAX = (64'sd1 <<< 23) - 64'sd1;
    localparam longint DLY_MIN = -(64'sd1 <<< 23);
    localparam longint HALF_LSB = 64'sd32768;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               guard_hit;
    } t_filtered;

    typedef struct packed {
        logic signed [17:0] b0;
        logic signed [17:0] b1;
        logic signed [17:0] b2;
        logic signed [17:0] a1;
        logic signed [17:0] a2;
    } t_coefs;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [REG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic signed [15:0]     x;
        logic                   typed;
        t_filtered              want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    biq_in_if  #(.SAMPLE_WIDTH(16)) in_bus ();
    biq_out_if #(.SAMPLE_WIDTH(16)) out_bus ();

    biquad_lowpass_filter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic               filt_on;
    logic signed [17:0] ff_b0, ff_b1, ff_b2, fb_a1, fb_a2;
    logic signed [23:0] dly1, dly2;

    t_filtered filtered_q[$];
    t_dir_row  dir_rows [N_DIR];
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        tx_gaps_on = 1'b1;
    bit        rx_stalls_on = 1'b1;
    bit        rx_long_hold = 1'b0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void set_register(input logic [REG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ENABLE:  filt_on = data[0];
            REG_COEF_B0: ff_b0 = data[17:0];
            REG_COEF_B1: ff_b1 = data[17:0];
            REG_COEF_B2: ff_b2 = data[17:0];
            REG_COEF_A1: fb_a1 = data[17:0];
            REG_COEF_A2: fb_a2 = data[17:0];
            default: ;
        endcase
    endfunction

    // direct form II step: w = x - a1*d1 - a2*d2, y = b0*w + b1*d1 + b2*d2
    function automatic t_filtered filter_step(input logic signed [15:0] x);
        t_filtered r;
        longint    acc;
        longint    w;
        longint    y;
        r.guard_hit = 1'b0;
        if (!filt_on) begin
            r.sample_out = x;
            return r;
        end
        acc = (longint'(x) <<< 16) - longint'(fb_a1) * longint'(dly1)
              - longint'(fb_a2) * longint'(dly2);
        w = (acc + HALF_LSB) >>> 16;
        if (w > DLY_MAX || w < DLY_MIN) begin
            w = longint'(x);
            r.guard_hit = 1'b1;
        end
        acc = longint'(ff_b0) * w + longint'(ff_b1) * longint'(dly1)
              + longint'(ff_b2) * longint'(dly2);
        y = (acc + HALF_LSB) >>> 16;
        if (y > longint'(S_MAX)) y = longint'(S_MAX);
        if (y < longint'(S_MIN)) y = longint'(S_MIN);
        r.sample_out = 16'(y);
        dly2 = dly1;
        dly1 = 24'(w);
        return r;
    endfunction

    function automatic t_dir_row word_row(input logic signed [15:0] x, input logic typed,
                                          input logic signed [15:0] y);
        t_dir_row row;
        row.kind = ROW_WORD;
        row.idx = REG_ENABLE;
        row.data = '0;
        row.x = x;
        row.typed = typed;
        row.want.sample_out = y;
        row.want.guard_hit = 1'b0;
        return row;
    endfunction

    function automatic t_dir_row reg_row(input logic [REG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        t_dir_row row;
        row = '0;
        row.kind = ROW_REG;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic logic signed [17:0] extreme_coef();
        case ($urandom_range(0, 3))
            0: return 18'sh20000;
            1: return 18'sh1FFFF;
            2: return 18'sh10000;
            default: return 18'sh00000;
        endcase
    endfunction

    function automatic logic signed [17:0] jitter(input int base);
        return 18'(base + int'($urandom_range(0, 32)) - 16);
    endfunction

    function automatic t_coefs pick_coefs(input int mode);
        t_coefs c;
        case (mode)
            0, 6, 7: begin
                c.b0 = 18'($urandom); c.b1 = 18'($urandom); c.b2 = 18'($urandom);
                c.a1 = 18'($urandom); c.a2 = 18'($urandom);
            end
            8: begin
                c.b0 = extreme_coef(); c.b1 = extreme_coef(); c.b2 = extreme_coef();
                c.a1 = extreme_coef(); c.a2 = extreme_coef();
            end
            9: begin
                c.b0 = 18'(int'($urandom_range(0, 8191)) - 4096);
                c.b1 = 18'(int'($urandom_range(0, 8191)) - 4096);
                c.b2 = 18'(int'($urandom_range(0, 8191)) - 4096);
                c.a1 = 18'(int'($urandom_range(0, 8191)) - 4096);
                c.a2 = 18'(int'($urandom_range(0, 8191)) - 4096);
            end
            default: begin
                // stable low-pass sets, cutoff at 0.1, 0.25 and 0.02 of the rate
                case ($urandom_range(0, 2))
                    0: begin
                        c.b0 = jitter(4426); c.b1 = jitter(8852); c.b2 = jitter(4426);
                        c.a1 = jitter(-74907); c.a2 = jitter(27054);
                    end
                    1: begin
                        c.b0 = jitter(19196); c.b1 = jitter(38392); c.b2 = jitter(19196);
                        c.a1 = jitter(0); c.a2 = jitter(11247);
                    end
                    default: begin
                        c.b0 = jitter(237); c.b1 = jitter(474); c.b2 = jitter(237);
                        c.a1 = jitter(-119454); c.a2 = jitter(54866);
                    end
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [17:0] v);
        logic [CFG_DATA_W-1:0] d;
        d = $urandom;
        d[17:0] = v;
        return d;
    endfunction

    function automatic logic signed [15:0] next_sample(input int kind,
                                                       input logic signed [15:0] prev);
        case (kind)
            1: begin
                case ($urandom_range(0, 3))
                    0: return S_MAX;
                    1: return S_MIN;
                    2: return 16'sd0;
                    default: return 16'($urandom);
                endcase
            end
            2: return ($urandom_range(0, 3) == 0) ? 16'($urandom) : prev;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        set_register(idx, data);
        @(posedge i_clk);
    endtask

    task automatic push_word(input logic signed [15:0] x, input logic typed,
                             input t_filtered want);
        int        gap;
        t_filtered r;
        gap = tx_gaps_on ? int'($urandom_range(0, 14)) : 0;
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.sample_in <= x;
        do @(posedge i_clk); while (!in_bus.ready);
        r = filter_step(x);
        filtered_q.push_back(typed ? want : r);
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                 phase;
        int                 rand_words;
        int                 mode;
        int                 kind;
        int                 len;
        t_coefs             c;
        logic signed [15:0] x;

        in_bus.valid     <= 1'b0;
        in_bus.sample_in <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        filt_on = 1'b0;
        ff_b0 = '0; ff_b1 = '0; ff_b2 = '0; fb_a1 = '0; fb_a2 = '0;
        dly1 = '0; dly2 = '0;

        dir_rows = '{
            word_row(S_MAX, 1'b1, S_MAX),
            word_row(S_MIN, 1'b1, S_MIN),
            word_row(16'sd0, 1'b1, 16'sd0),
            reg_row(REG_ENABLE, 32'd1),
            word_row(16'sd12345, 1'b1, 16'sd0),
            reg_row(REG_COEF_B0, 32'h0001_0000),
            word_row(S_MIN, 1'b1, S_MIN),
            word_row(S_MAX, 1'b1, S_MAX),
            reg_row(REG_COEF_B0, 32'h0001_FFFF),
            word_row(S_MAX, 1'b1, S_MAX),
            word_row(S_MIN, 1'b1, S_MIN),
            reg_row(REG_COEF_B0, 32'hFFFE_0000),
            word_row(S_MIN, 1'b1, S_MAX),
            word_row(S_MAX, 1'b1, S_MIN),
            reg_row(REG_ENABLE, 32'hFFFF_FFFE),
            word_row(16'sd1000, 1'b1, 16'sd1000),
            reg_row(REG_SPARE_6, 32'hFFFF_FFFF),
            reg_row(REG_ENABLE, 32'd1),
            reg_row(REG_COEF_B1, 32'h0001_FFFF),
            reg_row(REG_COEF_B2, 32'h0002_0000),
            reg_row(REG_COEF_A1, 32'h0002_0000),
            reg_row(REG_COEF_A2, 32'hFFFE_0000),
            // runaway feedback: delay term overflows and the sample stands in
            word_row(S_MAX, 1'b0, 16'sd0),
            word_row(S_MAX, 1'b0, 16'sd0),
            word_row(S_MAX, 1'b0, 16'sd0),
            word_row(S_MAX, 1'b0, 16'sd0),
            word_row(S_MAX, 1'b0, 16'sd0),
            word_row(S_MAX, 1'b0, 16'sd0),
            word_row(S_MAX, 1'b0, 16'sd0),
            word_row(S_MAX, 1'b0, 16'sd0),
            word_row(S_MIN, 1'b0, 16'sd0),
            word_row(S_MIN, 1'b0, 16'sd0),
            word_row(S_MIN, 1'b0, 16'sd0),
            word_row(S_MIN, 1'b0, 16'sd0),
            reg_row(REG_SPARE_7, 32'hFFFF_FFFF)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                wait_drained();
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                push_word(dir_rows[i].x, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        phase = 0;
        rand_words = 0;
        x = '0;
        while (rand_words < N_RANDOM) begin
            wait_drained();
            mode = $urandom_range(0, 9);
            c = pick_coefs(mode);
            cfg_write(REG_COEF_B0, with_noise(c.b0));
            cfg_write(REG_COEF_B1, with_noise(c.b1));
            cfg_write(REG_COEF_B2, with_noise(c.b2));
            cfg_write(REG_COEF_A1, with_noise(c.a1));
            cfg_write(REG_COEF_A2, with_noise(c.a2));
            cfg_write(REG_ENABLE, {31'($urandom), mode != 0});
            if ($urandom_range(0, 3) == 0)
                cfg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
            tx_gaps_on   = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            if (phase == 1 || $urandom_range(0, 14) == 0) begin
                rx_long_hold = 1'b1;
                tx_gaps_on   = 1'b0;
            end
            kind = $urandom_range(0, 3);
            len = $urandom_range(20, 120);
            repeat (len) begin
                x = next_sample(kind, x);
                push_word(x, 1'b0, '0);
                rand_words++;
            end
            phase++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : result_side
        int        stall;
        t_filtered want;
        out_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_long_hold) begin
                stall = LONG_HOLD;
                rx_long_hold = 1'b0;
            end else begin
                stall = rx_stalls_on ? int'($urandom_range(0, 14)) : 0;
            end
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!out_bus.valid);
            if (filtered_q.size() == 0) begin
                $error("unexpected word: sample_out %0d guard_hit %0d",
                       out_bus.sample_out, out_bus.guard_hit);
                fail_count++;
            end else begin
                want = filtered_q.pop_front();
                if (out_bus.sample_out !== want.sample_out) begin
                    $error("sample_out: expected %0d, got %0d",
                           want.sample_out, out_bus.sample_out);
                    fail_count++;
                end
                if (out_bus.guard_hit !== want.guard_hit) begin
                    $error("guard_hit: expected %0d, got %0d",
                           want.guard_hit, out_bus.guard_hit);
                    fail_count++;
                end
            end
        end
    end

endmodule

FILE: biquad_lowpass_filter.f
src/biq_pkg.sv
src/biq_if.sv
src/biquad_lowpass_filter.sv
sim/tb_biquad_lowpass_filter.sv
